[hw/rtl/balanced_delimiter_matcher_assert.svh]
// ----------------------------------------------------------------------------
// balanced_delimiter_matcher_assert.svh
// Assertion macros used by the delimiter matcher RTL.
// ----------------------------------------------------------------------------
`ifndef BALANCED_DELIMITER_MATCHER_ASSERT_SVH
`define BALANCED_DELIMITER_MATCHER_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define BDM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define BDM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/bdm_pkg.sv]
// ----------------------------------------------------------------------------
// bdm_pkg
// Types and constants of the balanced delimiter matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package bdm_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int DELIM_W     = 7;
   localparam int BYTE_W      = 8;
   localparam int OUT_W       = 17;

   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_DELIM  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_DELIM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_MODE   = 2'd2;

   localparam logic [DELIM_W-1:0] OPEN_DELIM_RESET  = 7'd123;
   localparam logic [DELIM_W-1:0] CLOSE_DELIM_RESET = 7'd125;

   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_PERCENT   = 8'h25;
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;

   localparam logic [1:0] UTF8_CONT_TAG = 2'b10;

   localparam logic signed [OUT_W-1:0] OUT_MAX  = 17'sd65535;
   localparam logic signed [OUT_W-1:0] NO_MATCH = -17'sd1;

   typedef struct packed {
      logic [DELIM_W-1:0] open_delim;
      logic [DELIM_W-1:0] close_delim;
      logic               char_mode;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/bdm_req_if.sv]
// ----------------------------------------------------------------------------
// bdm_req_if
// Input channel: one text byte per word with string framing flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       string_end;
   logic       empty_string;

   modport source (output valid, text_byte, string_end, empty_string, input ready);
   modport sink   (input valid, text_byte, string_end, empty_string, output ready);
endinterface

`default_nettype wire

[hw/rtl/bdm_rsp_if.sv]
// ----------------------------------------------------------------------------
// bdm_rsp_if
// Result channel: span start and length per finished string.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] match_start;
   logic signed [16:0] match_length;

   modport source (output valid, match_start, match_length, input ready);
   modport sink   (input valid, match_start, match_length, output ready);
endinterface

`default_nettype wire

[hw/rtl/bdm_scan.sv]
// ----------------------------------------------------------------------------
// bdm_scan
// Per-string scan state: escape, comment, nesting depth and positions.
// ----------------------------------------------------------------------------
`default_nettype none

module bdm_scan import bdm_pkg::*; #(
   parameter int POS_WIDTH   = 16,
   parameter int DEPTH_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 advance,
   input  logic [BYTE_W-1:0]    text_byte,
   input  logic                 last,
   input  logic                 empty_string,
   output logic                 done_in,
   output logic [POS_WIDTH-1:0] start_in,
   output logic [POS_WIDTH-1:0] end_in
);

   logic                   escape_ff, escape_in;
   logic                   comment_ff, comment_in;
   logic [DEPTH_WIDTH-1:0] depth_ff, depth_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   start_ff;
   logic [POS_WIDTH-1:0]   end_ff;
   logic                   done_ff;
   logic                   active;
   logic                   is_open;
   logic                   is_close;

   assign active   = !empty_string && !done_ff &&
                     !(cfg.char_mode && (text_byte[7:6] == UTF8_CONT_TAG));
   assign is_open  = (text_byte == {1'b0, cfg.open_delim});
   assign is_close = (text_byte == {1'b0, cfg.close_delim});

   always_comb begin
      escape_in  = escape_ff;
      comment_in = comment_ff;
      depth_in   = depth_ff;
      pos_in     = pos_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      done_in    = done_ff;
      if (active) begin
         if (comment_ff) begin
            if (text_byte == CH_NEWLINE) begin
               comment_in = 1'b0;
            end
         end else if (text_byte == CH_NEWLINE) begin
            escape_in = 1'b0;
         end else if (text_byte == CH_BACKSLASH) begin
            escape_in = !escape_ff;
         end else if (escape_ff) begin
            escape_in = 1'b0;
         end else if (text_byte == CH_PERCENT) begin
            comment_in = 1'b1;
         end else if (is_close) begin
            if (depth_ff > DEPTH_WIDTH'(1)) begin
               depth_in = depth_ff - DEPTH_WIDTH'(1);
            end else if (depth_ff == DEPTH_WIDTH'(1)) begin
               end_in  = pos_ff;
               done_in = 1'b1;
            end else if (cfg.open_delim == cfg.close_delim) begin
               start_in = pos_ff;
               depth_in = DEPTH_WIDTH'(1);
            end
         end else if (is_open) begin
            if (depth_ff == '0) begin
               start_in = pos_ff;
            end
            if (depth_ff != '1) begin
               depth_in = depth_ff + DEPTH_WIDTH'(1);
            end
         end
         if (pos_ff != '1) begin
            pos_in = pos_ff + POS_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last)) begin
         escape_ff  <= 1'b0;
         comment_ff <= 1'b0;
         depth_ff   <= '0;
         pos_ff     <= '0;
         start_ff   <= '0;
         end_ff     <= '0;
         done_ff    <= 1'b0;
      end else if (advance) begin
         escape_ff  <= escape_in;
         comment_ff <= comment_in;
         depth_ff   <= depth_in;
         pos_ff     <= pos_in;
         start_ff   <= start_in;
         end_ff     <= end_in;
         done_ff    <= done_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bdm_result.sv]
// ----------------------------------------------------------------------------
// bdm_result
// Result register: saturate span start and length, hold until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bdm_result import bdm_pkg::*; #(
   parameter int POS_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    take,
   input  logic                    done,
   input  logic [POS_WIDTH-1:0]    span_start,
   input  logic [POS_WIDTH-1:0]    span_end,
   output logic                    valid_ff,
   output logic signed [OUT_W-1:0] start_ff,
   output logic signed [OUT_W-1:0] length_ff
);

   localparam int SW = (POS_WIDTH + 1 > OUT_W) ? POS_WIDTH + 1 : OUT_W;

   logic [SW-1:0]           start_wide;
   logic [SW-1:0]           length_wide;
   logic signed [OUT_W-1:0] start_in;
   logic signed [OUT_W-1:0] length_in;

   assign start_wide  = SW'(span_start) + SW'(1);
   assign length_wide = SW'(span_end - span_start) + SW'(1);

   always_comb begin
      if (!done) begin
         start_in  = NO_MATCH;
         length_in = NO_MATCH;
      end else begin
         start_in  = (start_wide > SW'(OUT_MAX)) ? OUT_MAX : start_wide[OUT_W-1:0];
         length_in = (length_wide > SW'(OUT_MAX)) ? OUT_MAX : length_wide[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         start_ff  <= start_in;
         length_ff <= length_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/balanced_delimiter_matcher.sv]
// ----------------------------------------------------------------------------
// balanced_delimiter_matcher
// Finds the first balanced delimiter span of each string in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one text byte per word, with string_end on the last byte
//   of a string; a word with empty_string set carries no byte and ends the
//   string in progress. rsp_ch returns one word per finished string: the
//   1-based start and the length of the first balanced span, or -1 for both.
//   csr_we/csr_index/csr_wdata set the open delimiter, the close delimiter
//   and character mode; write them only while the block is idle.
//   Throughput: one byte per cycle, except while a string end waits for rsp_ch.
//   Results are registered: after its last word is accepted, a string's
//   result passes from the input register to the result register.
//   If rsp_ch stalls, the result register holds and bytes that end no string
//   keep flowing; a string end waits in the input register, and req_ch.ready
//   drops only while it waits.
//   Reset clears all scan state and the result valid flag and restores the
//   register defaults: open 123, close 125, character mode on.
// ----------------------------------------------------------------------------
`default_nettype none

module balanced_delimiter_matcher import bdm_pkg::*; #(
   parameter int POS_WIDTH   = 16,
   parameter int DEPTH_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   bdm_req_if.sink                req_ch,
   bdm_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "balanced_delimiter_matcher_assert.svh"

   cfg_type              cfg_ff;
   logic                 in_valid_ff;
   logic [BYTE_W-1:0]    in_byte_ff;
   logic                 in_end_ff;
   logic                 in_empty_ff;
   logic                 in_last;
   logic                 advance;
   logic                 accept;
   logic                 done_in;
   logic [POS_WIDTH-1:0] start_in;
   logic [POS_WIDTH-1:0] end_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_delim  <= OPEN_DELIM_RESET;
         cfg_ff.close_delim <= CLOSE_DELIM_RESET;
         cfg_ff.char_mode   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OPEN_DELIM:  cfg_ff.open_delim  <= csr_wdata;
            CSR_CLOSE_DELIM: cfg_ff.close_delim <= csr_wdata;
            CSR_CHAR_MODE:   cfg_ff.char_mode   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign in_last      = in_end_ff || in_empty_ff;
   assign advance      = in_valid_ff && (!in_last || !rsp_ch.valid || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff  <= req_ch.text_byte;
         in_end_ff   <= req_ch.string_end;
         in_empty_ff <= req_ch.empty_string;
      end
   end

   bdm_scan #(
      .POS_WIDTH   (POS_WIDTH),
      .DEPTH_WIDTH (DEPTH_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .advance      (advance),
      .text_byte    (in_byte_ff),
      .last         (in_last),
      .empty_string (in_empty_ff),
      .done_in      (done_in),
      .start_in     (start_in),
      .end_in       (end_in)
   );

   bdm_result #(
      .POS_WIDTH (POS_WIDTH)
   ) u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && in_last),
      .take       (rsp_ch.ready),
      .done       (done_in),
      .span_start (start_in),
      .span_end   (end_in),
      .valid_ff   (rsp_ch.valid),
      .start_ff   (rsp_ch.match_start),
      .length_ff  (rsp_ch.match_length)
   );

   `BDM_ASSERT_NXT(a_held_word_kept, clock, reset, in_valid_ff && !advance, in_valid_ff, "held input word lost")
   `BDM_ASSERT_IMP(a_ready_when_empty, clock, reset, !in_valid_ff, req_ch.ready, "input stage empty but not ready")
   `BDM_ASSERT_IMP(a_no_match_pair, clock, reset, rsp_ch.valid && (rsp_ch.match_start == NO_MATCH), rsp_ch.match_length == NO_MATCH, "no-match result with a length")
   `BDM_ASSERT_IMP(a_match_length_pos, clock, reset, rsp_ch.valid && (rsp_ch.match_start != NO_MATCH), rsp_ch.match_length > 17'sd0, "match without positive length")

endmodule

`default_nettype wire
